// File: hw/rtl/pfa_pkg.sv
// Shared constants for the paged frame allocator: field widths,
// status codes, opcodes and parameter defaults. No dependencies.

package pfa_pkg;

	// parameter defaults
	localparam int FRAMES_DEF    = 256;
	localparam int SLOTS_DEF     = 16;
	localparam int MAX_PAGES_DEF = 16;

	// fixed field widths
	localparam int OP_W     = 2;
	localparam int SLOT_W   = 4;
	localparam int SIZE_W   = 16;
	localparam int FRAME_W  = 9;
	localparam int PIDX_W   = 4;
	localparam int STATUS_W = 3;
	localparam int PSIZE_W  = 16;

	localparam int S_DATA_W = 32;
	localparam int M_DATA_W = 24;

	// opcodes
	localparam logic [OP_W-1:0] OP_SEED    = 2'd0;
	localparam logic [OP_W-1:0] OP_ALLOC   = 2'd1;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE    = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NOFRAMES = 3'd1;
	localparam logic [STATUS_W-1:0] ST_TOOMANY  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BUSY     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOPROC   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd5;

endpackage

// File: hw/rtl/pfa_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone; no package needed.

module pfa_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// hold the last read word until the next read
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/paged_frame_allocator_core.sv
// Paged frame allocator core: free frame ring, per-slot page tables,
// restoring divider and the op sequencer. Uses pfa_pkg and pfa_ram.
//
// Seed adds its frame to the ring if not full and returns one result. Allocate
// runs 16 divider steps on one shared compare/subtract unit, then returns one
// result per cycle, one per page, while the output is not stalled; release reads
// the page count, then returns one per page. Throughput: one item at a time;
// ready again after the last result is registered. Reset clears ring pointers,
// free count, slot flags and sets page_size to 1; ring and page-table memories are not cleared.

module paged_frame_allocator_core #(
	parameter int FRAMES    = pfa_pkg::FRAMES_DEF,
	parameter int SLOTS     = pfa_pkg::SLOTS_DEF,
	parameter int MAX_PAGES = pfa_pkg::MAX_PAGES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,

	// configuration: page_size
	input  logic                          cfg_we,
	input  logic [pfa_pkg::PSIZE_W-1:0]   cfg_wdata,

	// input beats
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [1:0] op, [5:2] process_slot, [21:6] process_size, [30:22] seed_frame,
	// [31] zero
	input  logic [pfa_pkg::S_DATA_W-1:0]  s_tdata,

	// result beats
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [3:0] slot_out, [7:4] page_index, [16:8] frame_out, [19:17] status,
	// [23:20] zero
	output logic [pfa_pkg::M_DATA_W-1:0]  m_tdata,
	output logic                          m_tlast
);

	localparam int RING_AW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CNT_W   = $clog2(FRAMES + 1);
	localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int PG_W    = $clog2(MAX_PAGES + 1);
	localparam int PF_DEPTH = SLOTS * MAX_PAGES;
	localparam int PF_AW   = (PF_DEPTH > 1) ? $clog2(PF_DEPTH) : 1;
	localparam int SUM_W   = ((CNT_W > PG_W) ? CNT_W : PG_W) + 1;
	localparam int SCMP_W  = 8;
	localparam int DCNT_W  = $clog2(pfa_pkg::SIZE_W);

	// sequencer states
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CHECK = 4'd1;
	localparam logic [3:0] S_DIV   = 4'd2;
	localparam logic [3:0] S_ACHK  = 4'd3;
	localparam logic [3:0] S_APOP  = 4'd4;
	localparam logic [3:0] S_RLEN  = 4'd5;
	localparam logic [3:0] S_RPUSH = 4'd6;
	localparam logic [3:0] S_EMIT  = 4'd7;

	// control state
	logic [3:0]                  state_q;
	logic [pfa_pkg::PSIZE_W-1:0] page_size_q;
	logic [RING_AW-1:0]          head_q, tail_q;
	logic [CNT_W-1:0]            count_q;
	logic [SLOTS-1:0]            active_q;
	logic                        m_tvalid_q;

	// item and work registers
	logic [pfa_pkg::OP_W-1:0]     op_q;
	logic [pfa_pkg::SLOT_W-1:0]   slot_q;
	logic [pfa_pkg::SIZE_W-1:0]   size_q;
	logic [pfa_pkg::FRAME_W-1:0]  seed_q;
	logic [pfa_pkg::SIZE_W-1:0]   rem_q, quot_q;
	logic [DCNT_W-1:0]            dcnt_q;
	logic [PG_W-1:0]              pages_q, pg_q;
	logic [PF_AW-1:0]             base_q;
	logic [pfa_pkg::FRAME_W-1:0]  res_frame_q;
	logic [pfa_pkg::STATUS_W-1:0] res_status_q;
	logic [pfa_pkg::M_DATA_W-1:0] m_tdata_q;
	logic                         m_tlast_q;

	// combinational
	logic                         out_free;
	logic                         in_acc;
	logic [SLOT_AW-1:0]           slot_idx;
	logic                         slot_bad;
	logic [pfa_pkg::SIZE_W:0]     trial;
	logic                         trial_ge;
	logic [RING_AW-1:0]           head_nxt, tail_nxt;
	logic                         pg_last;
	logic [SUM_W-1:0]             rel_sum;

	// memory ports
	logic                         ring_we, ring_re;
	logic [RING_AW-1:0]           ring_raddr;
	logic [pfa_pkg::FRAME_W-1:0]  ring_wdata, ring_rdata;
	logic                         pf_we, pf_re;
	logic [PF_AW-1:0]             pf_waddr, pf_raddr;
	logic [pfa_pkg::FRAME_W-1:0]  pf_rdata;
	logic                         sp_we, sp_re;
	logic [PG_W-1:0]              sp_rdata;

	// emission
	logic                         emit;
	logic [pfa_pkg::PIDX_W-1:0]   emit_page;
	logic [pfa_pkg::FRAME_W-1:0]  emit_frame;
	logic [pfa_pkg::STATUS_W-1:0] emit_status;
	logic                         emit_last;

	assign s_tready = (state_q == S_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign slot_idx = SLOT_AW'(slot_q);
	assign slot_bad = SCMP_W'(slot_q) >= SCMP_W'(SLOTS);

	// shared divider unit: one restoring compare/subtract per cycle
	assign trial    = {rem_q, quot_q[pfa_pkg::SIZE_W-1]};
	assign trial_ge = trial >= {1'b0, page_size_q};

	assign head_nxt = (head_q == RING_AW'(FRAMES - 1)) ? '0 : head_q + 1'b1;
	assign tail_nxt = (tail_q == RING_AW'(FRAMES - 1)) ? '0 : tail_q + 1'b1;
	assign pg_last  = (pg_q + 1'b1) == pages_q;
	assign rel_sum  = SUM_W'(count_q) + SUM_W'(sp_rdata);

	// memory control
	always_comb begin
		ring_we    = 1'b0;
		ring_wdata = seed_q;
		ring_re    = 1'b0;
		ring_raddr = head_q;
		pf_we      = 1'b0;
		pf_waddr   = base_q + PF_AW'(pg_q);
		pf_re      = 1'b0;
		pf_raddr   = base_q;
		sp_we      = 1'b0;
		sp_re      = 1'b0;
		case (state_q)
			S_CHECK: begin
				if (op_q == pfa_pkg::OP_SEED) begin
					ring_we = (count_q != CNT_W'(FRAMES));
				end else if (op_q == pfa_pkg::OP_RELEASE) begin
					sp_re = !slot_bad && active_q[slot_idx];
				end
			end
			S_ACHK: begin
				if (quot_q <= pfa_pkg::SIZE_W'(MAX_PAGES) &&
				    quot_q <= pfa_pkg::SIZE_W'(count_q)) begin
					sp_we   = 1'b1;
					ring_re = 1'b1;
				end
			end
			S_APOP: begin
				if (out_free) begin
					pf_we      = 1'b1;
					ring_re    = !pg_last;
					ring_raddr = head_nxt;
				end
			end
			S_RLEN: begin
				pf_re = 1'b1;
			end
			S_RPUSH: begin
				if (out_free) begin
					ring_we    = 1'b1;
					ring_wdata = pf_rdata;
					pf_re      = !pg_last;
					pf_raddr   = base_q + PF_AW'(pg_q) + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// result selection
	always_comb begin
		emit        = 1'b0;
		emit_page   = pfa_pkg::PIDX_W'(pg_q);
		emit_frame  = res_frame_q;
		emit_status = res_status_q;
		emit_last   = 1'b1;
		case (state_q)
			S_EMIT: begin
				emit      = out_free;
				emit_page = '0;
			end
			S_APOP: begin
				emit        = out_free;
				emit_frame  = ring_rdata;
				emit_status = pfa_pkg::ST_OK;
				emit_last   = pg_last;
			end
			S_RPUSH: begin
				emit        = out_free;
				emit_frame  = pf_rdata;
				emit_status = pfa_pkg::ST_OK;
				emit_last   = pg_last;
			end
			default: begin
			end
		endcase
	end

	// sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			page_size_q <= pfa_pkg::PSIZE_W'(1);
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			active_q    <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				page_size_q <= cfg_wdata;
			end

			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					case (op_q)
						pfa_pkg::OP_SEED: begin
							if (count_q != CNT_W'(FRAMES)) begin
								tail_q  <= tail_nxt;
								count_q <= count_q + 1'b1;
							end
							state_q <= S_EMIT;
						end
						pfa_pkg::OP_ALLOC: begin
							if (slot_bad || active_q[slot_idx]) begin
								state_q <= S_EMIT;
							end else begin
								state_q <= S_DIV;
							end
						end
						pfa_pkg::OP_RELEASE: begin
							if (slot_bad || !active_q[slot_idx]) begin
								state_q <= S_EMIT;
							end else begin
								state_q <= S_RLEN;
							end
						end
						default: begin
							// unused op: no result
							state_q <= S_IDLE;
						end
					endcase
				end
				S_DIV: begin
					if (dcnt_q == DCNT_W'(pfa_pkg::SIZE_W - 1)) begin
						state_q <= S_ACHK;
					end
				end
				S_ACHK: begin
					if (quot_q > pfa_pkg::SIZE_W'(MAX_PAGES) ||
					    quot_q > pfa_pkg::SIZE_W'(count_q)) begin
						state_q <= S_EMIT;
					end else begin
						active_q[slot_idx] <= 1'b1;
						state_q <= (quot_q == '0) ? S_EMIT : S_APOP;
					end
				end
				S_APOP: begin
					if (out_free) begin
						head_q  <= head_nxt;
						count_q <= count_q - 1'b1;
						if (pg_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_RLEN: begin
					if (rel_sum > SUM_W'(FRAMES)) begin
						state_q <= S_EMIT;
					end else begin
						active_q[slot_idx] <= 1'b0;
						state_q <= (sp_rdata == '0) ? S_EMIT : S_RPUSH;
					end
				end
				S_RPUSH: begin
					if (out_free) begin
						tail_q  <= tail_nxt;
						count_q <= count_q + 1'b1;
						if (pg_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item, divider and result payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q   <= s_tdata[1:0];
			slot_q <= s_tdata[5:2];
			size_q <= s_tdata[21:6];
			seed_q <= s_tdata[30:22];
		end

		if (emit) begin
			m_tdata_q <= {4'b0, emit_status, emit_frame, emit_page, slot_q};
			m_tlast_q <= emit_last;
		end

		case (state_q)
			S_CHECK: begin
				rem_q  <= '0;
				quot_q <= size_q;
				dcnt_q <= '0;
				pg_q   <= '0;
				base_q <= PF_AW'(slot_idx * MAX_PAGES);
				res_frame_q <= '0;
				case (op_q)
					pfa_pkg::OP_SEED: begin
						if (count_q != CNT_W'(FRAMES)) begin
							res_frame_q  <= seed_q;
							res_status_q <= pfa_pkg::ST_OK;
						end else begin
							res_status_q <= pfa_pkg::ST_FULL;
						end
					end
					pfa_pkg::OP_ALLOC: begin
						res_status_q <= slot_bad ? pfa_pkg::ST_NOPROC : pfa_pkg::ST_BUSY;
					end
					default: begin
						res_status_q <= pfa_pkg::ST_NOPROC;
					end
				endcase
			end
			S_DIV: begin
				// a zero page size yields an all-ones quotient: too many pages
				if (trial_ge) begin
					rem_q <= pfa_pkg::SIZE_W'(trial - {1'b0, page_size_q});
				end else begin
					rem_q <= trial[pfa_pkg::SIZE_W-1:0];
				end
				quot_q <= {quot_q[pfa_pkg::SIZE_W-2:0], trial_ge};
				dcnt_q <= dcnt_q + 1'b1;
			end
			S_ACHK: begin
				pages_q <= PG_W'(quot_q);
				if (quot_q > pfa_pkg::SIZE_W'(MAX_PAGES)) begin
					res_status_q <= pfa_pkg::ST_TOOMANY;
				end else if (quot_q > pfa_pkg::SIZE_W'(count_q)) begin
					res_status_q <= pfa_pkg::ST_NOFRAMES;
				end else begin
					res_status_q <= pfa_pkg::ST_OK;
				end
			end
			S_RLEN: begin
				pages_q <= sp_rdata;
				res_status_q <= (rel_sum > SUM_W'(FRAMES)) ? pfa_pkg::ST_FULL
				                                           : pfa_pkg::ST_OK;
			end
			S_APOP, S_RPUSH: begin
				if (out_free) begin
					pg_q <= pg_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	// free frame ring
	pfa_ram #(
		.WIDTH (pfa_pkg::FRAME_W),
		.DEPTH (FRAMES)
	) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (tail_q),
		.wdata (ring_wdata),
		.re    (ring_re),
		.raddr (ring_raddr),
		.rdata (ring_rdata)
	);

	// page tables, MAX_PAGES entries per slot
	pfa_ram #(
		.WIDTH (pfa_pkg::FRAME_W),
		.DEPTH (PF_DEPTH)
	) u_page_frames (
		.clk   (clk),
		.we    (pf_we),
		.waddr (pf_waddr),
		.wdata (ring_rdata),
		.re    (pf_re),
		.raddr (pf_raddr),
		.rdata (pf_rdata)
	);

	// page count per slot, only read while the slot is active
	pfa_ram #(
		.WIDTH (PG_W),
		.DEPTH (SLOTS)
	) u_slot_pages (
		.clk   (clk),
		.we    (sp_we),
		.waddr (slot_idx),
		.wdata (PG_W'(quot_q)),
		.re    (sp_re),
		.raddr (slot_idx),
		.rdata (sp_rdata)
	);

endmodule

// File: dv/paged_frame_allocator_core_tb.sv
// Self-checking testbench for paged_frame_allocator_core: directed table, then random
// seed/allocate/release traffic checked beat by beat against a behavioral frame ledger.
// Depends on pfa_pkg and the RTL of the core only.

module paged_frame_allocator_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pfa_pkg::*;

	localparam int FRAMES       = FRAMES_DEF;
	localparam int SLOTS        = SLOTS_DEF;
	localparam int MAX_PAGES    = MAX_PAGES_DEF;
	// drain wait: long enough for an allocate's divider steps and one beat per page, with margin
	localparam int DRAIN_CYCLES = 40;
	localparam int STALL_LIMIT  = 2000;

	// one request beat, as the ledger sees it
	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [SLOT_W-1:0]  slot;
		logic [SIZE_W-1:0]  bytes;
		logic [FRAME_W-1:0] seed;
	} frame_req_t;

	// one result beat
	typedef struct packed {
		logic [SLOT_W-1:0]   slot;
		logic [PIDX_W-1:0]   page;
		logic [FRAME_W-1:0]  frame;
		logic [STATUS_W-1:0] status;
		logic                last;
	} frame_beat_t;

	typedef enum logic {ROW_BEAT, ROW_PAGE_SIZE} row_kind_e;

	// directed row: either a page_size write or a request; typed rows carry their
	// single expected beat, the others are left to the ledger
	typedef struct packed {
		row_kind_e          kind;
		logic [PSIZE_W-1:0] page_size;
		logic [OP_W-1:0]    op;
		logic [SLOT_W-1:0]  slot;
		logic [SIZE_W-1:0]  bytes;
		logic [FRAME_W-1:0] seed;
		logic               typed;
		frame_beat_t        want;
	} plan_row_t;

	localparam frame_beat_t NO_WANT = '0;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [PSIZE_W-1:0]    cfg_wdata;
	logic                  s_tvalid;
	logic                  s_tready;
	// [1:0] op, [5:2] process_slot, [21:6] process_size, [30:22] seed_frame, [31] zero
	logic [S_DATA_W-1:0]   s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	// [3:0] slot_out, [7:4] page_index, [16:8] frame_out, [19:17] status, [23:20] zero
	logic [M_DATA_W-1:0]   m_tdata;
	logic                  m_tlast;

	// ledger state: free frame ring, page tables and slot flags
	logic [FRAME_W-1:0]    ring_frames [FRAMES];
	int                    ring_rd;
	int                    ring_wr;
	int                    free_frames;
	logic [FRAME_W-1:0]    slot_frames [SLOTS][MAX_PAGES];
	int                    slot_page_cnt [SLOTS];
	bit                    slot_live [SLOTS];
	int                    ledger_page_size;

	frame_beat_t           owed_beats [$];   // results still due from the core
	frame_beat_t           fresh_beats [$];  // results of the request just accepted

	bit                    steady;           // no idle cycles on either side
	int                    errors;
	int                    requests_sent;
	int                    beats_checked;
	int                    cfg_writes;
	int                    status_hits [8];
	int                    quiet_cycles;

	plan_row_t directed_plan [24] = '{
		// empty ring: allocate runs out of frames, release finds no process
		'{ROW_BEAT, 16'd0, OP_ALLOC,   4'd0,  16'd1,     9'd0,     1'b1,
			'{4'd0,  4'd0, 9'd0,     ST_NOFRAMES, 1'b1}},
		'{ROW_BEAT, 16'd0, OP_RELEASE, 4'd15, 16'd0,     9'd0,     1'b1,
			'{4'd15, 4'd0, 9'd0,     ST_NOPROC,   1'b1}},
		// page count over the table limit
		'{ROW_BEAT, 16'd0, OP_ALLOC,   4'd3,  16'd17,    9'd0,     1'b1,
			'{4'd3,  4'd0, 9'd0,     ST_TOOMANY,  1'b1}},
		'{ROW_BEAT, 16'd0, OP_ALLOC,   4'd3,  16'hffff,  9'd0,     1'b1,
			'{4'd3,  4'd0, 9'd0,     ST_TOOMANY,  1'b1}},
		// unused opcode with every bit set: no result at all
		'{ROW_BEAT, 16'd0, OP_NONE,    4'd15, 16'hffff,  9'h1ff,   1'b0, NO_WANT},
		// seed the ring, frame numbers at the extremes of the field
		'{ROW_BEAT, 16'd0, OP_SEED,    4'd5,  16'd0,     9'h1ff,   1'b1,
			'{4'd5,  4'd0, 9'h1ff,   ST_OK,       1'b1}},
		'{ROW_BEAT, 16'd0, OP_SEED,    4'd10, 16'd0,     9'd256,   1'b1,
			'{4'd10, 4'd0, 9'd256,   ST_OK,       1'b1}},
		'{ROW_BEAT, 16'd0, OP_SEED,    4'd0,  16'd0,     9'd1,     1'b1,
			'{4'd0,  4'd0, 9'd1,     ST_OK,       1'b1}},
		'{ROW_BEAT, 16'd0, OP_SEED,    4'd15, 16'hffff,  9'd0,     1'b1,
			'{4'd15, 4'd0, 9'd0,     ST_OK,       1'b1}},
		'{ROW_BEAT, 16'd0, OP_SEED,    4'd6,  16'd0,     9'h155,   1'b1,
			'{4'd6,  4'd0, 9'h155,   ST_OK,       1'b1}},
		'{ROW_BEAT, 16'd0, OP_SEED,    4'd9,  16'd0,     9'h0aa,   1'b1,
			'{4'd9,  4'd0, 9'h0aa,   ST_OK,       1'b1}},
		// zero-page process: allocate, busy on the second try, release
		'{ROW_BEAT, 16'd0, OP_ALLOC,   4'd0,  16'd0,     9'd0,     1'b1,
			'{4'd0,  4'd0, 9'd0,     ST_OK,       1'b1}},
		'{ROW_BEAT, 16'd0, OP_ALLOC,   4'd0,  16'd3,     9'd0,     1'b1,
			'{4'd0,  4'd0, 9'd0,     ST_BUSY,     1'b1}},
		'{ROW_BEAT, 16'd0, OP_RELEASE, 4'd0,  16'd0,     9'd0,     1'b1,
			'{4'd0,  4'd0, 9'd0,     ST_OK,       1'b1}},
		// take every seeded frame, then hand them back
		'{ROW_BEAT, 16'd0, OP_ALLOC,   4'd15, 16'd6,     9'd0,     1'b0, NO_WANT},
		'{ROW_BEAT, 16'd0, OP_ALLOC,   4'd1,  16'd1,     9'd0,     1'b1,
			'{4'd1,  4'd0, 9'd0,     ST_NOFRAMES, 1'b1}},
		'{ROW_BEAT, 16'd0, OP_RELEASE, 4'd15, 16'd0,     9'd0,     1'b0, NO_WANT},
		// zero page size saturates the quotient
		'{ROW_PAGE_SIZE, 16'd0, OP_NONE, 4'd0, 16'd0,   9'd0,     1'b0, NO_WANT},
		'{ROW_BEAT, 16'd0, OP_ALLOC,   4'd4,  16'd0,     9'd0,     1'b1,
			'{4'd4,  4'd0, 9'd0,     ST_TOOMANY,  1'b1}},
		// largest page size: one page at most
		'{ROW_PAGE_SIZE, 16'hffff, OP_NONE, 4'd0, 16'd0, 9'd0,    1'b0, NO_WANT},
		'{ROW_BEAT, 16'd0, OP_ALLOC,   4'd4,  16'hffff,  9'd0,     1'b0, NO_WANT},
		'{ROW_BEAT, 16'd0, OP_ALLOC,   4'd7,  16'hfffe,  9'd0,     1'b1,
			'{4'd7,  4'd0, 9'd0,     ST_OK,       1'b1}},
		'{ROW_BEAT, 16'd0, OP_RELEASE, 4'd7,  16'd0,     9'd0,     1'b1,
			'{4'd7,  4'd0, 9'd0,     ST_OK,       1'b1}},
		'{ROW_BEAT, 16'd0, OP_RELEASE, 4'd4,  16'd0,     9'd0,     1'b0, NO_WANT}
	};

	paged_frame_allocator_core #(
		.FRAMES    (FRAMES),
		.SLOTS     (SLOTS),
		.MAX_PAGES (MAX_PAGES)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic frame_req_t mk_req(input logic [OP_W-1:0] op,
			input logic [SLOT_W-1:0] slot, input logic [SIZE_W-1:0] bytes,
			input logic [FRAME_W-1:0] seed);
		frame_req_t rq;
		rq.op    = op;
		rq.slot  = slot;
		rq.bytes = bytes;
		rq.seed  = seed;
		return rq;
	endfunction

	function automatic frame_beat_t mk_beat(input logic [SLOT_W-1:0] slot, input int page,
			input logic [FRAME_W-1:0] frame, input logic [STATUS_W-1:0] status,
			input logic last);
		frame_beat_t b;
		b.slot   = slot;
		b.page   = PIDX_W'(page);
		b.frame  = frame;
		b.status = status;
		b.last   = last;
		return b;
	endfunction

	// Apply one accepted request to the ledger and leave its results in fresh_beats.
	task automatic account_request(input frame_req_t rq);
		int pages;
		fresh_beats.delete();
		case (rq.op)
			OP_SEED: begin
				if (free_frames >= FRAMES) begin
					fresh_beats.push_back(mk_beat(rq.slot, 0, '0, ST_FULL, 1'b1));
				end else begin
					ring_frames[ring_wr] = rq.seed;
					ring_wr = (ring_wr + 1) % FRAMES;
					free_frames++;
					fresh_beats.push_back(mk_beat(rq.slot, 0, rq.seed, ST_OK, 1'b1));
				end
			end
			OP_ALLOC: begin
				pages = (ledger_page_size == 0) ? 0 : int'(rq.bytes) / ledger_page_size;
				if (slot_live[rq.slot]) begin
					fresh_beats.push_back(mk_beat(rq.slot, 0, '0, ST_BUSY, 1'b1));
				end else if (ledger_page_size == 0 || pages > MAX_PAGES) begin
					fresh_beats.push_back(mk_beat(rq.slot, 0, '0, ST_TOOMANY, 1'b1));
				end else if (pages > free_frames) begin
					fresh_beats.push_back(mk_beat(rq.slot, 0, '0, ST_NOFRAMES, 1'b1));
				end else begin
					slot_live[rq.slot] = 1'b1;
					slot_page_cnt[rq.slot] = pages;
					if (pages == 0)
						fresh_beats.push_back(mk_beat(rq.slot, 0, '0, ST_OK, 1'b1));
					// pop one frame per page from the ring head, in page order
					for (int i = 0; i < pages; i++) begin
						slot_frames[rq.slot][i] = ring_frames[ring_rd];
						ring_rd = (ring_rd + 1) % FRAMES;
						free_frames--;
						fresh_beats.push_back(mk_beat(rq.slot, i, slot_frames[rq.slot][i],
							ST_OK, i == pages - 1));
					end
				end
			end
			OP_RELEASE: begin
				pages = slot_page_cnt[rq.slot];
				if (!slot_live[rq.slot]) begin
					fresh_beats.push_back(mk_beat(rq.slot, 0, '0, ST_NOPROC, 1'b1));
				end else if (free_frames + pages > FRAMES) begin
					// frames would not fit back: slot stays allocated
					fresh_beats.push_back(mk_beat(rq.slot, 0, '0, ST_FULL, 1'b1));
				end else begin
					slot_live[rq.slot] = 1'b0;
					slot_page_cnt[rq.slot] = 0;
					if (pages == 0)
						fresh_beats.push_back(mk_beat(rq.slot, 0, '0, ST_OK, 1'b1));
					for (int i = 0; i < pages; i++) begin
						ring_frames[ring_wr] = slot_frames[rq.slot][i];
						ring_wr = (ring_wr + 1) % FRAMES;
						free_frames++;
						fresh_beats.push_back(mk_beat(rq.slot, i, slot_frames[rq.slot][i],
							ST_OK, i == pages - 1));
					end
				end
			end
			default: ;	// unused opcode: ignored
		endcase
	endtask

	// Present one request beat after a random gap and hold it until the core takes it.
	// Returns at the falling edge after acceptance with tvalid still high.
	task automatic push_request(input frame_req_t rq, input logic typed,
			input frame_beat_t want);
		int gap;
		gap = steady ? 0 : $urandom_range(16);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  <= {1'b0, rq.seed, rq.bytes, rq.slot, rq.op};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		account_request(rq);
		if (typed)
			owed_beats.push_back(want);
		else
			foreach (fresh_beats[i]) owed_beats.push_back(fresh_beats[i]);
		requests_sent++;
		@(negedge clk);
	endtask

	// Write page_size with the core idle: all results in, then a latency's worth of quiet.
	task automatic write_page_size(input logic [PSIZE_W-1:0] value);
		s_tvalid <= 1'b0;
		while (owed_beats.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		ledger_page_size = value;
		cfg_writes++;
	endtask

	// Pick a process size that splits into the given number of pages.
	function automatic logic [SIZE_W-1:0] size_for_pages(input int pages);
		int lo;
		int hi;
		if (ledger_page_size == 0)
			return SIZE_W'($urandom);
		lo = pages * ledger_page_size;
		if (lo > 65535)
			return SIZE_W'($urandom);
		hi = lo + ledger_page_size - 1;
		if (hi > 65535)
			hi = 65535;
		return SIZE_W'($urandom_range(hi, lo));
	endfunction

	// Mostly well-formed traffic: allocate into free slots within the free frame
	// count, release live slots; the rest are errors and noise.
	task automatic draw_request(output frame_req_t rq);
		int pick;
		int fit;
		logic [SLOT_W-1:0] cand [$];
		pick = $urandom_range(99);
		rq = mk_req(OP_SEED, SLOT_W'($urandom), SIZE_W'($urandom),
			FRAME_W'($urandom_range(256, 1)));
		if (pick < 35) begin
			if ($urandom_range(3) == 0)
				rq.seed = FRAME_W'($urandom);
		end else if (pick < 92) begin
			rq.op = (pick < 65) ? OP_ALLOC : OP_RELEASE;
			// free slots for allocate, live slots for release
			for (int s = 0; s < SLOTS; s++)
				if (slot_live[s] == (rq.op == OP_RELEASE))
					cand.push_back(SLOT_W'(s));
			if (cand.size() != 0 && $urandom_range(9) != 0)
				rq.slot = cand[$urandom_range(cand.size() - 1)];
			if (rq.op == OP_ALLOC) begin
				fit = (free_frames < MAX_PAGES) ? free_frames : MAX_PAGES;
				case ($urandom_range(9))
					0: ;	// keep the raw random size
					1: rq.bytes = size_for_pages($urandom_range(MAX_PAGES + 4, MAX_PAGES + 1));
					2: rq.bytes = size_for_pages($urandom_range(MAX_PAGES));
					default: rq.bytes = size_for_pages($urandom_range(fit));
				endcase
			end
		end else if (pick < 96) begin
			rq.op = OP_NONE;
		end else begin
			rq.op = OP_W'($urandom);
			rq.seed = FRAME_W'($urandom);
		end
	endtask

	// Random traffic until the given number of non-ignored requests went in.
	task automatic run_mix(input int count);
		frame_req_t rq;
		int done;
		done = 0;
		while (done < count) begin
			draw_request(rq);
			push_request(rq, 1'b0, NO_WANT);
			if (rq.op != OP_NONE)
				done++;
		end
	endtask

	// Bring the ring to full with one slot still holding frames, then hit both the
	// full-ring seed and the release overflow.
	task automatic run_fill();
		int pages;
		for (int s = 0; s < SLOTS; s++)
			if (slot_live[s])
				push_request(mk_req(OP_RELEASE, SLOT_W'(s), SIZE_W'($urandom),
					FRAME_W'($urandom)), 1'b0, NO_WANT);
		pages = (free_frames < 4) ? free_frames : 4;
		if (pages > 0)
			push_request(mk_req(OP_ALLOC, SLOT_W'($urandom), size_for_pages(
				$urandom_range(pages, 1)), '0), 1'b0, NO_WANT);
		while (free_frames < FRAMES)
			push_request(mk_req(OP_SEED, SLOT_W'($urandom), SIZE_W'($urandom),
				FRAME_W'($urandom)), 1'b0, NO_WANT);
		repeat (2)
			push_request(mk_req(OP_SEED, SLOT_W'($urandom), '0,
				FRAME_W'($urandom_range(256, 1))), 1'b0, NO_WANT);
		for (int s = 0; s < SLOTS; s++)
			if (slot_live[s])
				push_request(mk_req(OP_RELEASE, SLOT_W'(s), '0, '0), 1'b0, NO_WANT);
	endtask

	task automatic compare_field(input string what, input int want, input int got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
			errors++;
		end
	endtask

	// Check one accepted result beat against the oldest owed result.
	task automatic check_result_beat();
		frame_beat_t got;
		frame_beat_t want;
		got.slot   = m_tdata[3:0];
		got.page   = m_tdata[7:4];
		got.frame  = m_tdata[16:8];
		got.status = m_tdata[19:17];
		got.last   = m_tlast;
		if (owed_beats.size() == 0) begin
			$display("%0t ns: unexpected result beat, expected none, got slot %0d page %0d frame %0d status %0d last %0d",
				$time, got.slot, got.page, got.frame, got.status, got.last);
			errors++;
		end else begin
			want = owed_beats.pop_front();
			compare_field("slot_out",   want.slot,   got.slot);
			compare_field("page_index", want.page,   got.page);
			compare_field("frame_out",  want.frame,  got.frame);
			compare_field("status",     want.status, got.status);
			compare_field("last",       want.last,   got.last);
			status_hits[got.status]++;
		end
		beats_checked++;
	endtask

	// Result side: draw a stall per beat, then hold tready until a beat is taken.
	initial begin : result_sink
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = steady ? 0 : $urandom_range(16);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			check_result_beat();
		end
	end

	// Watchdog: end the run when no beat and no register write moves for too long.
	initial quiet_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t ns: no handshake for %0d cycles", $time, STALL_LIMIT);
			$display("paged_frame_allocator_core regression: fail");
			$finish;
		end
	end

	initial begin : stimulus
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		steady    = 1'b0;

		// ledger after reset: empty ring, every slot free, page_size 1
		ring_rd          = 0;
		ring_wr          = 0;
		free_frames      = 0;
		ledger_page_size = 1;
		foreach (slot_live[s]) begin
			slot_live[s]     = 1'b0;
			slot_page_cnt[s] = 0;
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (directed_plan[i]) begin
			if (directed_plan[i].kind == ROW_PAGE_SIZE)
				write_page_size(directed_plan[i].page_size);
			else
				push_request(mk_req(directed_plan[i].op, directed_plan[i].slot,
					directed_plan[i].bytes, directed_plan[i].seed),
					directed_plan[i].typed, directed_plan[i].want);
		end

		// random phases over several page sizes
		write_page_size(16'd1);
		run_mix(40);
		write_page_size(16'd4096);
		steady = 1'b1;	// back-to-back beats on both sides
		run_mix(40);
		steady = 1'b0;
		write_page_size(PSIZE_W'($urandom_range(64, 2)));
		run_fill();
		write_page_size(16'hffff);
		run_mix(20);
		write_page_size(PSIZE_W'($urandom_range(65535, 1)));
		run_mix(40);

		// drop valid, collect what is still owed, then watch for strays
		s_tvalid <= 1'b0;
		while (owed_beats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests, %0d result beats, %0d page_size writes",
			requests_sent, beats_checked, cfg_writes);
		$display("statuses: ok %0d, no frames %0d, too many %0d, busy %0d, no process %0d, ring full %0d",
			status_hits[ST_OK], status_hits[ST_NOFRAMES], status_hits[ST_TOOMANY],
			status_hits[ST_BUSY], status_hits[ST_NOPROC], status_hits[ST_FULL]);
		if (errors == 0)
			$display("paged_frame_allocator_core regression: pass");
		else
			$display("paged_frame_allocator_core regression: fail");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/pfa_pkg.sv
hw/rtl/pfa_ram.sv
hw/rtl/paged_frame_allocator_core.sv
dv/paged_frame_allocator_core_tb.sv
